[src/ktt_pkg.sv]
// Shared types, constants and codes for the keyed target table.
package ktt_pkg;

   localparam int NUM_ENTRIES = 32;
   localparam int SLOT_W      = $clog2(NUM_ENTRIES);
   localparam int CNT_W       = $clog2(NUM_ENTRIES + 1);
   localparam logic [CNT_W-1:0] ENTRY_CNT = CNT_W'(NUM_ENTRIES);

   localparam int ID_W    = 30;
   localparam int CLS_W   = 2;
   localparam int AGE_W   = 16;
   localparam int FR_W    = 2;
   localparam int KIND_W  = 2;
   localparam int SLOTO_W = 6;
   localparam int THR_W   = 16;

   localparam logic [AGE_W-1:0] AGE_MAX = '1;

   // operation codes (req_tuser)
   localparam logic OP_REPORT = 1'b0;
   localparam logic OP_TICK   = 1'b1;

   // event kinds
   localparam logic [KIND_W-1:0] EV_UPDATED = 2'd0;
   localparam logic [KIND_W-1:0] EV_EXPIRED = 2'd1;
   localparam logic [KIND_W-1:0] EV_FULL    = 2'd2;

   // freshness grades
   localparam logic [FR_W-1:0] FR_CURRENT = 2'd0;
   localparam logic [FR_W-1:0] FR_STALE   = 2'd1;
   localparam logic [FR_W-1:0] FR_LOST    = 2'd2;

   localparam logic [CLS_W-1:0] CLS_UNKNOWN = 2'd0;

   // register indexes
   localparam logic CSR_STALE = 1'b0;
   localparam logic CSR_LOST  = 1'b1;

   typedef struct packed {
      logic [ID_W-1:0]  key;
      logic [CLS_W-1:0] kind;
      logic [AGE_W-1:0] age;
      logic [FR_W-1:0]  fresh;
   } entry_type;

   typedef struct packed {
      logic              en;
      logic [SLOT_W-1:0] addr;
      entry_type         data;
   } tbl_wr_type;

   typedef struct packed {
      logic              en;
      logic [SLOT_W-1:0] addr;
   } tbl_rd_type;

   typedef struct packed {
      logic [AGE_W-1:0] age_next;
      logic [FR_W-1:0]  grade;
      logic             changed;
   } grade_type;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [SLOTO_W-1:0] slot;
      logic [ID_W-1:0]    id;
      logic [CLS_W-1:0]   cls;
      logic [FR_W-1:0]    fresh;
   } result_type;

endpackage

[src/ktt_table.sv]
// Entry store: one write port, one read port with registered read data.
module ktt_table
   import ktt_pkg::*;
(
   input  logic       clock,
   input  tbl_rd_type rd,
   input  tbl_wr_type wr,
   output entry_type  rd_data
);

   entry_type mem [NUM_ENTRIES];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      if (rd.en) begin
         rd_data_ff <= mem[rd.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[src/ktt_grade.sv]
// Shared ageing unit: saturating increment and grading against both thresholds.
module ktt_grade
   import ktt_pkg::*;
(
   input  logic [AGE_W-1:0] age,
   input  logic [FR_W-1:0]  fresh,
   input  logic [THR_W-1:0] stale_thr,
   input  logic [THR_W-1:0] lost_thr,
   output grade_type        res
);

   logic [AGE_W-1:0] age_n;
   logic [FR_W-1:0]  grade;

   always_comb begin
      age_n = (age == AGE_MAX) ? age : age + AGE_W'(1);
      if (age_n < stale_thr) begin
         grade = FR_CURRENT;
      end else if (age_n < lost_thr) begin
         grade = FR_STALE;
      end else begin
         grade = FR_LOST;
      end
      res.age_next = age_n;
      res.grade    = grade;
      res.changed  = (grade != fresh);
   end

endmodule

[src/keyed_target_table_with_aging.sv]
// Top level: keyed target table with aging, sequencer and result staging.
//
// req channel: one transaction per command. req_tuser selects a vessel report
// (0) or a one-second tick (1). A report with identity 0 is absorbed silently.
// A report scans all slots through the single read port of the entry store,
// then updates or allocates the slot and gives one result (updated, or table
// full). A tick walks the table twice through the same port and the shared
// ageing unit: first ageing and regrading each entry (updated events), then
// expiring the lost entries.
// rsp channel: results in order; rsp_tlast marks the final result of a command.
// One result is held back in a staging register until it is known whether it
// is the last; a stalled receiver stalls the walk, nothing is dropped.
// req_tready is high only while the sequencer is idle; a finished result may
// still wait in the output register while the next command is taken.
// csr channel: always ready; index 0 stale threshold, 1 lost threshold.
// Reset: synchronous, active high; clears all slots and the output, thresholds
// back to 180 and 360 seconds. No clearing pass is needed.
module keyed_target_table_with_aging
   import ktt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // target_id[29:0], vessel_class[31:30]
   input  logic        req_tuser,   // operation
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // slot[5:0], entry_id[35:6], entry_class[37:36],
                                    // freshness[39:38]
   output logic [1:0]  rsp_tuser,   // event_kind
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_SCAN   = 6'b000010,
      S_UPDATE = 6'b000100,
      S_AGE    = 6'b001000,
      S_EXPIRE = 6'b010000,
      S_FLUSH  = 6'b100000
   } state_type;

   state_type              state_ff, state_in;
   logic [CNT_W-1:0]       rd_idx_ff, rd_idx_in;
   logic                   st_valid_ff, st_valid_in;
   logic [SLOT_W-1:0]      st_idx_ff, st_idx_in;
   logic [NUM_ENTRIES-1:0] valid_ff, valid_in;
   logic [NUM_ENTRIES-1:0] lost_ff, lost_in;
   logic [THR_W-1:0]       stale_thr_ff, stale_thr_in;
   logic [THR_W-1:0]       lost_thr_ff, lost_thr_in;
   logic                   pend_valid_ff, pend_valid_in;
   result_type             pend_ff, pend_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   result_type             rsp_ff, rsp_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic [ID_W-1:0]        req_id_ff, req_id_in;
   logic [CLS_W-1:0]       req_cls_ff, req_cls_in;
   logic                   hit_found_ff, hit_found_in;
   logic [SLOT_W-1:0]      hit_idx_ff, hit_idx_in;
   logic [CLS_W-1:0]       hit_kind_ff, hit_kind_in;
   logic                   free_found_ff, free_found_in;
   logic [SLOT_W-1:0]      free_idx_ff, free_idx_in;

   tbl_rd_type             tbl_rd;
   tbl_wr_type             tbl_wr;
   entry_type              rdata;
   grade_type              grd;

   logic                   adv;
   logic                   need;
   logic                   emit;
   result_type             emit_res;
   logic                   emit_ok;
   logic                   walk_done;
   logic [CLS_W-1:0]       kind_new;
   logic [ID_W-1:0]        in_id;
   logic [CLS_W-1:0]       in_cls;

   ktt_table u_table (
      .clock   (clock),
      .rd      (tbl_rd),
      .wr      (tbl_wr),
      .rd_data (rdata)
   );

   ktt_grade u_grade (
      .age       (rdata.age),
      .fresh     (rdata.fresh),
      .stale_thr (stale_thr_ff),
      .lost_thr  (lost_thr_ff),
      .res       (grd)
   );

   assign in_id      = req_tdata[ID_W-1:0];
   assign in_cls     = req_tdata[ID_W+CLS_W-1:ID_W];
   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;
   assign emit_ok    = !pend_valid_ff || !rsp_valid_ff || rsp_tready;
   assign walk_done  = (rd_idx_ff == ENTRY_CNT) && !st_valid_ff;
   assign kind_new   = (req_cls_ff != CLS_UNKNOWN) ? req_cls_ff : hit_kind_ff;

   always_comb begin
      state_in      = state_ff;
      rd_idx_in     = rd_idx_ff;
      st_valid_in   = st_valid_ff;
      st_idx_in     = st_idx_ff;
      valid_in      = valid_ff;
      lost_in       = lost_ff;
      stale_thr_in  = stale_thr_ff;
      lost_thr_in   = lost_thr_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_in        = rsp_ff;
      rsp_last_in   = rsp_last_ff;
      req_id_in     = req_id_ff;
      req_cls_in    = req_cls_ff;
      hit_found_in  = hit_found_ff;
      hit_idx_in    = hit_idx_ff;
      hit_kind_in   = hit_kind_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      tbl_rd        = '0;
      tbl_wr        = '0;
      adv           = 1'b0;
      need          = 1'b0;
      emit          = 1'b0;
      emit_res      = '0;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_valid) begin
         case (csr_index)
            CSR_STALE: stale_thr_in = csr_wdata;
            CSR_LOST:  lost_thr_in  = csr_wdata;
            default:   ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               rd_idx_in     = '0;
               st_valid_in   = 1'b0;
               req_id_in     = in_id;
               req_cls_in    = in_cls;
               hit_found_in  = 1'b0;
               free_found_in = 1'b0;
               if (req_tuser == OP_TICK) begin
                  lost_in  = '0;
                  state_in = S_AGE;
               end else if (in_id != '0) begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            adv = 1'b1;
            if (st_valid_ff) begin
               if (valid_ff[st_idx_ff]) begin
                  if (!hit_found_ff && rdata.key == req_id_ff) begin
                     hit_found_in = 1'b1;
                     hit_idx_in   = st_idx_ff;
                     hit_kind_in  = rdata.kind;
                  end
               end else if (!free_found_ff) begin
                  free_found_in = 1'b1;
                  free_idx_in   = st_idx_ff;
               end
            end
            if (walk_done) begin
               state_in = S_UPDATE;
            end
         end
         S_UPDATE: begin
            emit = 1'b1;
            tbl_wr.data.key   = req_id_ff;
            tbl_wr.data.age   = '0;
            tbl_wr.data.fresh = FR_CURRENT;
            if (hit_found_ff) begin
               tbl_wr.en        = 1'b1;
               tbl_wr.addr      = hit_idx_ff;
               tbl_wr.data.kind = kind_new;
               emit_res = '{EV_UPDATED, SLOTO_W'(hit_idx_ff), req_id_ff, kind_new, FR_CURRENT};
            end else if (free_found_ff) begin
               tbl_wr.en             = 1'b1;
               tbl_wr.addr           = free_idx_ff;
               tbl_wr.data.kind      = req_cls_ff;
               valid_in[free_idx_ff] = 1'b1;
               emit_res = '{EV_UPDATED, SLOTO_W'(free_idx_ff), req_id_ff, req_cls_ff,
                            FR_CURRENT};
            end else begin
               emit_res = '{EV_FULL, '0, req_id_ff, req_cls_ff, FR_CURRENT};
            end
            state_in = S_FLUSH;
         end
         S_AGE: begin
            need = st_valid_ff && valid_ff[st_idx_ff] && grd.grade != FR_LOST && grd.changed;
            adv  = !(need && !emit_ok);
            if (adv && st_valid_ff && valid_ff[st_idx_ff]) begin
               if (grd.grade == FR_LOST) begin
                  lost_in[st_idx_ff] = 1'b1;
               end else begin
                  tbl_wr.en         = 1'b1;
                  tbl_wr.addr       = st_idx_ff;
                  tbl_wr.data.key   = rdata.key;
                  tbl_wr.data.kind  = rdata.kind;
                  tbl_wr.data.age   = grd.age_next;
                  tbl_wr.data.fresh = grd.grade;
               end
               if (need) begin
                  emit     = 1'b1;
                  emit_res = '{EV_UPDATED, SLOTO_W'(st_idx_ff), rdata.key, rdata.kind,
                               grd.grade};
               end
            end
            if (walk_done) begin
               rd_idx_in = '0;
               state_in  = S_EXPIRE;
            end
         end
         S_EXPIRE: begin
            need = st_valid_ff && lost_ff[st_idx_ff];
            adv  = !(need && !emit_ok);
            if (adv && need) begin
               emit                = 1'b1;
               emit_res            = '{EV_EXPIRED, SLOTO_W'(st_idx_ff), rdata.key, rdata.kind,
                                       FR_LOST};
               valid_in[st_idx_ff] = 1'b0;
               lost_in[st_idx_ff]  = 1'b0;
            end
            if (walk_done) begin
               state_in = S_FLUSH;
            end
         end
         S_FLUSH: begin
            if (!pend_valid_ff) begin
               state_in = S_IDLE;
            end else if (!rsp_valid_ff || rsp_tready) begin
               rsp_in        = pend_ff;
               rsp_last_in   = 1'b1;
               rsp_valid_in  = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // walk pipeline: read one slot ahead of the one being processed
      if (adv && !walk_done) begin
         if (rd_idx_ff < ENTRY_CNT) begin
            tbl_rd.en   = 1'b1;
            tbl_rd.addr = rd_idx_ff[SLOT_W-1:0];
            rd_idx_in   = rd_idx_ff + CNT_W'(1);
            st_valid_in = 1'b1;
            st_idx_in   = rd_idx_ff[SLOT_W-1:0];
         end else begin
            st_valid_in = 1'b0;
         end
      end

      // a new result pushes the held one out, which is then known not to be last
      if (emit) begin
         if (pend_valid_ff) begin
            rsp_in       = pend_ff;
            rsp_last_in  = 1'b0;
            rsp_valid_in = 1'b1;
         end
         pend_in       = emit_res;
         pend_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rd_idx_ff     <= '0;
         st_valid_ff   <= 1'b0;
         valid_ff      <= '0;
         lost_ff       <= '0;
         stale_thr_ff  <= THR_W'(180);
         lost_thr_ff   <= THR_W'(360);
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         hit_found_ff  <= 1'b0;
         free_found_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rd_idx_ff     <= rd_idx_in;
         st_valid_ff   <= st_valid_in;
         valid_ff      <= valid_in;
         lost_ff       <= lost_in;
         stale_thr_ff  <= stale_thr_in;
         lost_thr_ff   <= lost_thr_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         hit_found_ff  <= hit_found_in;
         free_found_ff <= free_found_in;
      end
   end

   always_ff @(posedge clock) begin
      st_idx_ff   <= st_idx_in;
      pend_ff     <= pend_in;
      rsp_ff      <= rsp_in;
      rsp_last_ff <= rsp_last_in;
      req_id_ff   <= req_id_in;
      req_cls_ff  <= req_cls_in;
      hit_idx_ff  <= hit_idx_in;
      hit_kind_ff <= hit_kind_in;
      free_idx_ff <= free_idx_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_ff.fresh, rsp_ff.cls, rsp_ff.id, rsp_ff.slot};
   assign rsp_tuser  = rsp_ff.kind;
   assign rsp_tlast  = rsp_last_ff;

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the keyed target table with ageing.
module tb_top
   import ktt_pkg::*;
();

   localparam int RUN_LIMIT   = 1_000_000;
   localparam int WALK_CYCLES = 2 * NUM_ENTRIES + 16;
   localparam int LONG_HOLD   = 400;
   localparam int POOL_SIZE   = 40;

   typedef struct packed {
      logic             op;
      logic [ID_W-1:0]  id;
      logic [CLS_W-1:0] cls;
   } target_cmd_type;

   typedef struct {
      logic [KIND_W-1:0]  kind;
      logic [SLOTO_W-1:0] slot;
      logic [ID_W-1:0]    id;
      logic [CLS_W-1:0]   cls;
      logic [FR_W-1:0]    fresh;
      logic               last;
   } target_event_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;   // target_id[29:0], vessel_class[31:30]
   logic        req_tuser = 1'b0; // operation
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;        // slot[5:0], entry_id[35:6], entry_class[37:36],
                                  // freshness[39:38]
   logic [1:0]  rsp_tuser;        // event_kind
   logic        rsp_tlast;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_index = CSR_STALE;
   logic [15:0] csr_wdata = '0;

   // predicted table contents and thresholds
   logic             trk_valid [NUM_ENTRIES];
   logic [ID_W-1:0]  trk_id    [NUM_ENTRIES];
   logic [CLS_W-1:0] trk_cls   [NUM_ENTRIES];
   logic [AGE_W-1:0] trk_age   [NUM_ENTRIES];
   logic [FR_W-1:0]  trk_grade [NUM_ENTRIES];
   logic [THR_W-1:0] stale_limit = 16'd180;
   logic [THR_W-1:0] lost_limit  = 16'd360;

   target_cmd_type   cmd_queue[$];
   target_event_type due_events[$];
   target_cmd_type   offered_cmd;
   logic [ID_W-1:0] id_pool [POOL_SIZE];

   int   send_idle_pct = 0;
   int   rsp_stall_pct = 0;
   int   error_count   = 0;
   int   cycle_count   = 0;
   int   hold_left     = 0;
   logic hold_go       = 1'b0;

   always #1 clock = ~clock;

   keyed_target_table_with_aging u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   function automatic target_event_type make_event(logic [KIND_W-1:0] kind, int slot,
                                                   logic [ID_W-1:0] id,
                                                   logic [CLS_W-1:0] cls,
                                                   logic [FR_W-1:0] fresh);
      target_event_type ev;
      ev.kind  = kind;
      ev.slot  = SLOTO_W'(slot);
      ev.id    = id;
      ev.cls   = cls;
      ev.fresh = fresh;
      ev.last  = 1'b0;
      return ev;
   endfunction

   // Apply one accepted command to the predicted table and queue its events.
   task automatic track_command(target_cmd_type cmd);
      target_event_type run[$];
      target_event_type expired[$];
      logic [FR_W-1:0] grade;
      int hit;
      int free_slot;
      hit = -1;
      free_slot = -1;
      if (cmd.op == OP_REPORT) begin
         if (cmd.id == '0)
            return;
         for (int i = 0; i < NUM_ENTRIES; i++) begin
            if (trk_valid[i]) begin
               if (hit < 0 && trk_id[i] == cmd.id)
                  hit = i;
            end else if (free_slot < 0) begin
               free_slot = i;
            end
         end
         if (hit < 0 && free_slot < 0) begin
            run.push_back(make_event(EV_FULL, 0, cmd.id, cmd.cls, FR_CURRENT));
         end else begin
            if (hit < 0) begin
               hit = free_slot;
               trk_valid[hit] = 1'b1;
               trk_id[hit]    = cmd.id;
               trk_cls[hit]   = cmd.cls;
            end else if (cmd.cls != CLS_UNKNOWN) begin
               trk_cls[hit] = cmd.cls;
            end
            trk_age[hit]   = '0;
            trk_grade[hit] = FR_CURRENT;
            run.push_back(make_event(EV_UPDATED, hit, trk_id[hit], trk_cls[hit],
                                     FR_CURRENT));
         end
      end else begin
         for (int i = 0; i < NUM_ENTRIES; i++) begin
            if (!trk_valid[i])
               continue;
            if (trk_age[i] != AGE_MAX)
               trk_age[i] = trk_age[i] + 1'b1;
            if (trk_age[i] < stale_limit)
               grade = FR_CURRENT;
            else if (trk_age[i] < lost_limit)
               grade = FR_STALE;
            else
               grade = FR_LOST;
            if (grade == FR_LOST) begin
               expired.push_back(make_event(EV_EXPIRED, i, trk_id[i], trk_cls[i], FR_LOST));
               trk_valid[i] = 1'b0;
            end else if (grade != trk_grade[i]) begin
               trk_grade[i] = grade;
               run.push_back(make_event(EV_UPDATED, i, trk_id[i], trk_cls[i], grade));
            end
         end
         foreach (expired[k])
            run.push_back(expired[k]);
      end
      if (run.size() != 0)
         run[run.size() - 1].last = 1'b1;
      foreach (run[k])
         due_events.push_back(run[k]);
   endtask

   // command driver
   always @(posedge clock) begin : cmd_driver
      target_cmd_type next_cmd;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            track_command(offered_cmd);
         if (!req_tvalid || req_tready) begin
            if (cmd_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               next_cmd = cmd_queue.pop_front();
               offered_cmd <= next_cmd;
               req_tvalid  <= 1'b1;
               req_tdata   <= {next_cmd.cls, next_cmd.id};
               req_tuser   <= next_cmd.op;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold-off, counted here
   always @(posedge clock) begin
      if (reset)
         hold_left <= 0;
      else if (hold_go)
         hold_left <= LONG_HOLD;
      else if (hold_left != 0)
         hold_left <= hold_left - 1;
   end

   task automatic flag_mismatch(string field, logic [31:0] want, logic [31:0] got);
      error_count++;
      $display("%0t: %s expected %0h actual %0h", $realtime, field, want, got);
   endtask

   // event monitor
   always @(posedge clock) begin : event_monitor
      target_event_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (due_events.size() == 0) begin
               error_count++;
               $display("%0t: unexpected event, expected none actual kind %0h slot %0d id %0h",
                        $realtime, rsp_tuser, rsp_tdata[5:0], rsp_tdata[35:6]);
            end else begin
               want = due_events.pop_front();
               if (rsp_tuser !== want.kind)
                  flag_mismatch("event_kind", 32'(want.kind), 32'(rsp_tuser));
               if (rsp_tdata[5:0] !== want.slot)
                  flag_mismatch("slot", 32'(want.slot), 32'(rsp_tdata[5:0]));
               if (rsp_tdata[35:6] !== want.id)
                  flag_mismatch("entry_id", 32'(want.id), 32'(rsp_tdata[35:6]));
               if (rsp_tdata[37:36] !== want.cls)
                  flag_mismatch("entry_class", 32'(want.cls), 32'(rsp_tdata[37:36]));
               if (rsp_tdata[39:38] !== want.fresh)
                  flag_mismatch("freshness", 32'(want.fresh), 32'(rsp_tdata[39:38]));
               if (rsp_tlast !== want.last)
                  flag_mismatch("last_of_run", 32'(want.last), 32'(rsp_tlast));
            end
         end
         rsp_tready <= (hold_left == 0) && ($urandom_range(0, 99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= RUN_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   task automatic queue_cmd(logic op, logic [ID_W-1:0] id, logic [CLS_W-1:0] cls);
      target_cmd_type cmd;
      cmd.op  = op;
      cmd.id  = id;
      cmd.cls = cls;
      cmd_queue.push_back(cmd);
   endtask

   task automatic wait_until_drained();
      while (cmd_queue.size() != 0 || req_tvalid || due_events.size() != 0)
         @(negedge clock);
   endtask

   task automatic write_threshold(logic idx, logic [THR_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do
         @(posedge clock);
      while (!(csr_valid && csr_ready));
      if (idx == CSR_STALE)
         stale_limit = value;
      else
         lost_limit = value;
      csr_valid <= 1'b0;
   endtask

   // a tick that gives no event may still be walking the table
   task automatic settle_and_configure(logic [THR_W-1:0] stale, logic [THR_W-1:0] lost);
      wait_until_drained();
      repeat (WALK_CYCLES) @(posedge clock);
      write_threshold(CSR_STALE, stale);
      write_threshold(CSR_LOST, lost);
      @(negedge clock);
   endtask

   // mostly reports from a pool larger than the table, some ticks, some noise
   task automatic queue_random(int count, int tick_pct);
      int roll;
      for (int n = 0; n < count; n++) begin
         roll = $urandom_range(0, 99);
         if (roll < tick_pct)
            queue_cmd(OP_TICK, ID_W'($urandom), CLS_W'($urandom));
         else if (roll < tick_pct + 4)
            queue_cmd(OP_REPORT, '0, CLS_W'($urandom));
         else if ($urandom_range(0, 4) == 0)
            queue_cmd(OP_REPORT, ID_W'($urandom), CLS_W'($urandom));
         else
            queue_cmd(OP_REPORT, id_pool[$urandom_range(0, POOL_SIZE - 1)],
                      CLS_W'($urandom));
      end
   endtask

   task automatic run_phase(int idle_pct, int stall_pct, logic [THR_W-1:0] stale,
                            logic [THR_W-1:0] lost, int tick_pct);
      settle_and_configure(stale, lost);
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      queue_random(44, tick_pct);
   endtask

   initial begin
      foreach (trk_valid[i])
         trk_valid[i] = 1'b0;
      foreach (id_pool[i]) begin
         id_pool[i] = ID_W'($urandom);
         if (id_pool[i] == '0)
            id_pool[i] = ID_W'(i + 1);
      end
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: default thresholds, class handling, identity extremes
      queue_cmd(OP_REPORT, '0, 2'd3);
      queue_cmd(OP_REPORT, {ID_W{1'b1}}, 2'd3);
      queue_cmd(OP_REPORT, ID_W'(1), CLS_UNKNOWN);
      queue_cmd(OP_REPORT, ID_W'(1), CLS_UNKNOWN);
      queue_cmd(OP_REPORT, ID_W'(1), 2'd2);
      queue_cmd(OP_REPORT, ID_W'(1), CLS_UNKNOWN);
      queue_cmd(OP_REPORT, 30'h2AAA_AAAA, 2'd1);
      queue_cmd(OP_TICK, 30'h1555_5555, 2'd2);
      // short thresholds: stale then lost
      settle_and_configure(16'd2, 16'd3);
      queue_cmd(OP_TICK, '0, CLS_UNKNOWN);
      queue_cmd(OP_REPORT, 30'h1555_5555, 2'd2);
      queue_cmd(OP_TICK, '0, CLS_UNKNOWN);
      queue_cmd(OP_TICK, '0, CLS_UNKNOWN);
      queue_cmd(OP_TICK, '0, CLS_UNKNOWN);
      // lost at or below stale: never graded stale
      settle_and_configure(16'd5, 16'd2);
      queue_cmd(OP_REPORT, ID_W'(7), 2'd1);
      queue_cmd(OP_TICK, '0, CLS_UNKNOWN);
      queue_cmd(OP_TICK, '0, CLS_UNKNOWN);
      // zero thresholds are always reached
      settle_and_configure(16'd0, 16'd0);
      queue_cmd(OP_REPORT, ID_W'(9), 2'd3);
      queue_cmd(OP_TICK, '0, CLS_UNKNOWN);
      settle_and_configure(16'd0, 16'hFFFF);
      queue_cmd(OP_REPORT, ID_W'(11), 2'd2);
      queue_cmd(OP_TICK, '0, CLS_UNKNOWN);
      queue_cmd(OP_REPORT, ID_W'(11), CLS_UNKNOWN);
      queue_cmd(OP_TICK, '0, CLS_UNKNOWN);

      // random phases
      run_phase(0, 0, 16'd3, 16'd6, 25);
      run_phase(88, 0, 16'd1, 16'd2, 20);
      run_phase(0, 88, 16'd4, 16'hFFFF, 15);
      run_phase(11, 11, 16'hFFFF, 16'd5, 20);

      // receiver holds off while reports and ticks pile up behind it
      settle_and_configure(16'd1, 16'd2);
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      @(posedge clock);
      hold_go <= 1'b1;
      @(posedge clock);
      hold_go <= 1'b0;
      @(negedge clock);
      for (int n = 0; n < 14; n++)
         queue_cmd(OP_REPORT, id_pool[n], CLS_W'($urandom));
      queue_cmd(OP_TICK, '0, CLS_UNKNOWN);
      for (int n = 14; n < 20; n++)
         queue_cmd(OP_REPORT, id_pool[n], CLS_W'($urandom));
      queue_cmd(OP_TICK, '0, CLS_UNKNOWN);
      queue_cmd(OP_TICK, '0, CLS_UNKNOWN);

      wait_until_drained();
      repeat (WALK_CYCLES) @(posedge clock);
      if (error_count == 0 && due_events.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

[sim.f]
src/ktt_pkg.sv
src/ktt_table.sv
src/ktt_grade.sv
src/keyed_target_table_with_aging.sv
tb/tb_top.sv
